### sv/vertex_transform_perspective_divide_assert.svh
// Assertion helpers for the vertex transform block
`ifndef VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH
`define VERTEX_TRANSFORM_PERSPECTIVE_DIVIDE_ASSERT_SVH

// same-cycle implication, masked during reset
`define VTPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define VTPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always armed
`define VTPD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/vtpd_pkg.sv
package vtpd_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int NREGS         = 8;
   localparam int CSR_IDX_W     = 4;
   localparam int REM_W         = 66;   // holds |acc| << FRAC_BITS for any FRAC_BITS
   localparam int Q_W           = 33;   // quotient bits kept, enough to spot saturation
   localparam int ZW_GAIN       = 1000000;
   localparam int ZW_MAX_MAG    = 2147; // largest |acc| whose 1e6 multiple fits

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [Q_W-1:0]   quo;
      logic             neg;
      logic             ovf;
   } lane_type;

   typedef struct packed {
      lane_type [2:0]    lane;
      logic [31:0]       mw;
      logic [31:0]       w;
      logic              w_sat;
      logic              w_zero;
      logic [2:0][31:0]  zw_val;
      logic [2:0]        zw_sat;
      logic              last;
   } div_item_type;

endpackage

### sv/vtpd_mac.sv
module vtpd_mac #(
   parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF,
   parameter int ACC_W     = 65 - FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            adv,
   input  logic                  in_valid,
   input  logic [2:0][31:0]      vert,
   input  logic                  in_last,
   input  logic [7:0][63:0]      matrix,
   output logic [1:0]            valid,
   output logic [3:0][ACC_W-1:0] acc,
   output logic                  out_last
);

   logic [3:0][2:0][63:0] prod_ff, prod_in;
   logic [3:0][ACC_W-1:0] acc_ff, acc_in;
   logic [1:0]            valid_ff;
   logic                  last0_ff, last1_ff;

   always_comb begin
      logic signed [31:0] ea, vb;
      logic signed [63:0] sh;
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 3; k++) begin
            ea = matrix[2*r + k/2][32*(k%2) +: 32];
            vb = vert[k];
            prod_in[r][k] = 64'(ea * vb);
         end
      end
      for (int r = 0; r < 4; r++) begin
         // column 3 entry is the translation term, taken as is
         acc_in[r] = {{(ACC_W-32){matrix[2*r+1][63]}}, matrix[2*r+1][63:32]};
         for (int k = 0; k < 3; k++) begin
            sh = $signed(prod_ff[r][k]) >>> FRAC_BITS;  // floor rounding
            acc_in[r] = acc_in[r] + sh[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
      end
      if (adv[0]) begin
         prod_ff  <= prod_in;
         last0_ff <= in_last;
      end
      if (adv[1]) begin
         acc_ff   <= acc_in;
         last1_ff <= last0_ff;
      end
   end

   assign valid    = valid_ff;
   assign acc      = acc_ff;
   assign out_last = last1_ff;

endmodule

### sv/vtpd_prep.sv
module vtpd_prep #(
   parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF,
   parameter int ACC_W     = 65 - FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             adv,
   input  logic                   in_valid,
   input  logic [3:0][ACC_W-1:0]  acc,
   input  logic                   in_last,
   output logic [1:0]             valid,
   output vtpd_pkg::div_item_type item
);

   logic [1:0]            valid_ff;
   logic [31:0]           wq_ff, wq_in;
   logic                  wsat_ff, wsat_in;
   logic [2:0][ACC_W-1:0] ma_ff, ma_in;
   logic [2:0]            aneg_ff;
   logic                  last_ff;
   vtpd_pkg::div_item_type item_ff, item_in;

   // stage A: clamp w, magnitudes of x, y, z
   always_comb begin
      logic hi_same;
      hi_same = (acc[3][ACC_W-1:31] == '0) || (acc[3][ACC_W-1:31] == '1);
      wsat_in = !hi_same;
      if (hi_same)             wq_in = acc[3][31:0];
      else if (acc[3][ACC_W-1]) wq_in = 32'h8000_0000;
      else                     wq_in = 32'h7FFF_FFFF;
      for (int i = 0; i < 3; i++) begin
         ma_in[i] = acc[i][ACC_W-1] ? (~acc[i] + 1'b1) : acc[i];
      end
   end

   // stage B: divisor, early overflow check, zero-w path
   always_comb begin
      logic                        wneg;
      logic [31:0]                 mw;
      logic [vtpd_pkg::REM_W-1:0]  num, lim;
      logic [31:0]                 zmag;
      logic                        big;
      wneg = wq_ff[31];
      mw   = wneg ? (~wq_ff + 1'b1) : wq_ff;
      item_in.mw     = mw;
      item_in.w      = wq_ff;
      item_in.w_sat  = wsat_ff;
      item_in.w_zero = (wq_ff == '0);
      item_in.last   = last_ff;
      lim = {{(vtpd_pkg::REM_W-32){1'b0}}, mw} << (vtpd_pkg::Q_W - FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
         num = {{(vtpd_pkg::REM_W-ACC_W){1'b0}}, ma_ff[i]};
         item_in.lane[i].rem = num << FRAC_BITS;
         item_in.lane[i].quo = '0;
         item_in.lane[i].ovf = (num >= lim);
         // z divides by |w|, so only its own sign counts
         item_in.lane[i].neg = (i == 2) ? aneg_ff[i] : (aneg_ff[i] ^ wneg);
         big  = (ma_ff[i] > ACC_W'(vtpd_pkg::ZW_MAX_MAG));
         zmag = {20'd0, ma_ff[i][11:0]} * 32'(vtpd_pkg::ZW_GAIN);
         item_in.zw_sat[i] = big;
         if (big)             item_in.zw_val[i] = aneg_ff[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else if (aneg_ff[i]) item_in.zw_val[i] = ~zmag + 1'b1;
         else                 item_in.zw_val[i] = zmag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= in_valid;
         if (adv[1]) valid_ff[1] <= valid_ff[0];
      end
      if (adv[0]) begin
         wq_ff   <= wq_in;
         wsat_ff <= wsat_in;
         ma_ff   <= ma_in;
         aneg_ff <= {acc[2][ACC_W-1], acc[1][ACC_W-1], acc[0][ACC_W-1]};
         last_ff <= in_last;
      end
      if (adv[1]) item_ff <= item_in;
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

### sv/vtpd_div_stage.sv
module vtpd_div_stage #(
   parameter int BIT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  vtpd_pkg::div_item_type in_item,
   output logic                   valid,
   output vtpd_pkg::div_item_type out_item
);

   logic                   valid_ff;
   vtpd_pkg::div_item_type item_ff, item_in;

   // one restoring step per lane
   always_comb begin
      logic [vtpd_pkg::REM_W-1:0] sub;
      item_in = in_item;
      sub = {{(vtpd_pkg::REM_W-32){1'b0}}, in_item.mw} << BIT;
      for (int l = 0; l < 3; l++) begin
         if (in_item.lane[l].rem >= sub) begin
            item_in.lane[l].rem      = in_item.lane[l].rem - sub;
            item_in.lane[l].quo[BIT] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) item_ff <= item_in;
   end

   assign valid    = valid_ff;
   assign out_item = item_ff;

endmodule

### sv/vertex_transform_perspective_divide.sv
// Pipeline: 2 multiply/sum, 2 prep, 33 divide steps and 1 output stage, with
// the divider resolving one quotient bit per stage.
// Throughput: one vertex per cycle; each stage holds when the next is full.
// Reset: synchronous, clears all stage valids and loads the identity matrix.
module vertex_transform_perspective_divide #(
   parameter int FRAC_BITS = vtpd_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [95:0]                    req_tdata,   // vert_x, vert_y, vert_z
   input  logic                           req_tlast,   // last_vertex
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [127:0]                   rsp_tdata,   // out_x, out_y, out_z, out_w
   output logic                           rsp_tuser,   // saturated
   output logic                           rsp_tlast,   // last_out
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [vtpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_data
);

   localparam int ACC_W = 65 - FRAC_BITS;
   localparam int NDIV  = vtpd_pkg::Q_W;
   localparam int NST   = 4 + NDIV + 1;
   localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

   logic [7:0][63:0]      mat_ff;
   logic [NST-1:0]        vld, adv;
   logic [3:0][ACC_W-1:0] acc;
   logic                  acc_last;
   vtpd_pkg::div_item_type items [NDIV+1];

   logic                  out_valid_ff;
   logic [127:0]          out_data_ff, out_data_in;
   logic                  out_sat_ff, out_sat_in;
   logic                  out_last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mat_ff <= {ONE << 32, 64'd0, ONE, 64'd0, 64'd0, ONE << 32, 64'd0, ONE};
      end else if (csr_valid && csr_index < vtpd_pkg::CSR_IDX_W'(vtpd_pkg::NREGS)) begin
         mat_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // a stage moves when it is empty or the one after it moves
   always_comb begin
      adv[NST-1] = !vld[NST-1] || rsp_tready;
      for (int k = NST-2; k >= 0; k--) begin
         adv[k] = !vld[k] || adv[k+1];
      end
   end

   assign req_tready = adv[0];

   vtpd_mac #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_mac (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv[1:0]),
      .in_valid (req_tvalid),
      .vert     ({req_tdata[95:64], req_tdata[63:32], req_tdata[31:0]}),
      .in_last  (req_tlast),
      .matrix   (mat_ff),
      .valid    (vld[1:0]),
      .acc      (acc),
      .out_last (acc_last)
   );

   vtpd_prep #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv[3:2]),
      .in_valid (vld[1]),
      .acc      (acc),
      .in_last  (acc_last),
      .valid    (vld[3:2]),
      .item     (items[0])
   );

   for (genvar j = 0; j < NDIV; j++) begin : g_div
      vtpd_div_stage #(.BIT(NDIV-1-j)) u_stage (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv[4+j]),
         .in_valid (vld[3+j]),
         .in_item  (items[j]),
         .valid    (vld[4+j]),
         .out_item (items[j+1])
      );
   end

   // sign, saturation, zero-w select
   always_comb begin
      logic [vtpd_pkg::Q_W-1:0] lim, mag;
      logic                     s;
      logic [31:0]              val;
      vtpd_pkg::div_item_type   d;
      d = items[NDIV];
      out_sat_in = d.w_sat;
      out_data_in[127:96] = d.w;
      out_data_in[95:0]   = '0;
      for (int l = 0; l < 3; l++) begin
         lim = d.lane[l].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
         s   = d.lane[l].ovf || (d.lane[l].quo > lim);
         mag = s ? lim : d.lane[l].quo;
         val = d.lane[l].neg ? (~mag[31:0] + 1'b1) : mag[31:0];
         if (d.w_zero) begin
            val = d.zw_val[l];
            s   = d.zw_sat[l];
         end
         out_data_in[32*l +: 32] = val;
         out_sat_in = out_sat_in | s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv[NST-1]) begin
         out_valid_ff <= vld[NST-2];
      end
      if (adv[NST-1]) begin
         out_data_ff <= out_data_in;
         out_sat_ff  <= out_sat_in;
         out_last_ff <= items[NDIV].last;
      end
   end

   assign vld[NST-1] = out_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### sv/vtpd_checker.sv
`include "vertex_transform_perspective_divide_assert.svh"

module vtpd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         rsp_tlast
);

   `VTPD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result valid after reset")
   `VTPD_ASSERT_NOW(a_drain_ready, clock, reset, rsp_tready || !rsp_tvalid, req_tready, "input stalled while output drains")
   `VTPD_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "stalled result dropped")
   `VTPD_ASSERT_NEXT(a_hold_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

endmodule

bind vertex_transform_perspective_divide vtpd_checker u_vtpd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB = vtpd_pkg::FRAC_BITS_DEF;
   localparam int NREG = vtpd_pkg::NREGS;
   localparam int LATENCY = 38;

   typedef struct packed {
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic        last;
   } vertex_type;

   typedef struct packed {
      logic [31:0] ox;
      logic [31:0] oy;
      logic [31:0] oz;
      logic [31:0] ow;
      logic        sat;
      logic        last;
   } projected_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [vtpd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   logic [63:0] matrix_regs [NREG];
   projected_type expected_q [$];
   int errors = 0;
   bit stall_on = 1'b1;

   always #6 clock = ~clock;

   vertex_transform_perspective_divide u_dut (.*);

   function automatic longint coef(int r, int c);
      logic [63:0] rg;
      rg = matrix_regs[2 * r + c / 2];
      return (c % 2) ? longint'($signed(rg[63:32])) : longint'($signed(rg[31:0]));
   endfunction

   // clamp magnitude, set flag on clip; returns 32-bit two's complement
   function automatic logic [31:0] clip_mag(bit neg, logic [63:0] mag, ref bit sat);
      logic [63:0] lim;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag > lim) begin
         mag = lim;
         sat = 1'b1;
      end
      return neg ? 32'(0 - mag) : 32'(mag);
   endfunction

   function automatic logic [31:0] clip_val(longint v, ref bit sat);
      return clip_mag(v < 0, v < 0 ? 64'(-v) : 64'(v), sat);
   endfunction

   function automatic logic [31:0] div_fixed(longint a, longint w, ref bit sat);
      bit neg;
      logic [63:0] ma, mw, q, r, mag;
      neg = (a < 0) != (w < 0);
      ma = a < 0 ? 64'(-a) : 64'(a);
      mw = w < 0 ? 64'(-w) : 64'(w);
      q = ma / mw;
      r = ma % mw;
      if (q > 64'hFFFF_FFFF) mag = '1;
      else mag = (q << FB) + ((r << FB) / mw);
      return clip_mag(neg && mag != 0, mag, sat);
   endfunction

   function automatic logic [31:0] zero_w_gain(longint a, ref bit sat);
      logic [63:0] ma, mag;
      ma = a < 0 ? 64'(-a) : 64'(a);
      mag = (ma > 64'h1_0000_0000) ? '1 : ma * 64'd1000000;
      return clip_mag(a < 0, mag, sat);
   endfunction

   function automatic projected_type project_vertex(vertex_type vin);
      longint v [3];
      longint acc [4];
      longint p, wq, aw;
      bit sat;
      projected_type o;
      sat = 1'b0;
      v[0] = $signed(vin.vx);
      v[1] = $signed(vin.vy);
      v[2] = $signed(vin.vz);
      for (int r = 0; r < 4; r++) begin
         acc[r] = coef(r, 3);
         for (int k = 0; k < 3; k++) begin
            p = coef(r, k) * v[k];
            acc[r] += p >>> FB;   // arithmetic shift floors
         end
      end
      o.ow = clip_val(acc[3], sat);
      wq = $signed(o.ow);
      if (wq != 0) begin
         aw = wq < 0 ? -wq : wq;
         o.ox = div_fixed(acc[0], wq, sat);
         o.oy = div_fixed(acc[1], wq, sat);
         o.oz = div_fixed(acc[2], aw, sat);
      end else begin
         o.ox = zero_w_gain(acc[0], sat);
         o.oy = zero_w_gain(acc[1], sat);
         o.oz = zero_w_gain(acc[2], sat);
      end
      o.sat = sat;
      o.last = vin.last;
      return o;
   endfunction

   function automatic bit idle_now();
      return stall_on && ($urandom_range(99) < 36);
   endfunction

   // leaves valid high after the beat; the caller or the next idle drops it
   task automatic send_vertex(vertex_type vin);
      if (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (idle_now()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {vin.vz, vin.vy, vin.vx};
      req_tlast <= vin.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_q.push_back(project_vertex(vin));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // leaves csr_valid high after the beat; the caller drops it
   task automatic write_reg(int idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx[vtpd_pkg::CSR_IDX_W-1:0];
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < NREG) matrix_regs[idx] = val;
   endtask

   task automatic load_matrix(logic [31:0] m [16]);
      for (int r = 0; r < 4; r++) begin
         write_reg(2 * r, {m[4 * r + 1], m[4 * r]});
         write_reg(2 * r + 1, {m[4 * r + 3], m[4 * r + 2]});
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic vertex_type rand_vertex(int shift);
      vertex_type v;
      v.vx = $urandom() >>> shift;
      v.vy = $urandom() >>> shift;
      v.vz = $urandom() >>> shift;
      if ($urandom_range(1)) begin
         v.vx = -v.vx; v.vy = -v.vy;
      end
      if ($urandom_range(1)) v.vz = -v.vz;
      v.last = ($urandom_range(7) == 0);
      return v;
   endfunction

   task automatic test_identity_edges();
      logic [31:0] ext [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 32'h1_0000};
      for (int i = 0; i < 6; i++)
         send_vertex('{ext[i], ext[5 - i], ext[(i + 2) % 6], i[0]});
      drain();
   endtask

   // w row chosen so w comes out zero, large, or negative
   task automatic test_w_cases();
      logic [31:0] m [16] = '{32'h1_0000, 0, 0, 0, 0, 32'h1_0000, 0, 0,
                              0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000, 0};
      load_matrix(m);   // w = z: z = 0 gives the zero-w path
      send_vertex('{32'h0000_0100, 32'hFFFF_FF00, 32'h0, 1'b0});
      send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1});
      send_vertex('{32'h0, 32'h0, 32'h0, 1'b0});
      send_vertex('{32'h3_0000, 32'h2_0000, 32'hFFFF_0000, 1'b0});
      send_vertex('{32'h3_0000, 32'h8000_0000, 32'h0000_0001, 1'b1});
      send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0});
      drain();
      for (int i = 0; i < 16; i++) m[i] = 32'h7FFF_FFFF;
      load_matrix(m);
      send_vertex('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0});
      send_vertex('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1});
      drain();
      for (int i = 0; i < 16; i++) m[i] = 32'h8000_0000;
      load_matrix(m);
      send_vertex('{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0});
      send_vertex('{32'hFFFF_FFFF, 32'h1, 32'h0, 1'b1});
      drain();
      write_reg(NREG + 3, 64'hDEAD_BEEF_0000_0000);   // out-of-range index, ignored
      csr_valid <= 1'b0;
      send_vertex('{32'h1_0000, 32'h2_0000, 32'h3_0000, 1'b0});
      drain();
   endtask

   task automatic test_random(int n);
      logic [31:0] m [16];
      for (int phase = 0; phase < 8; phase++) begin
         for (int i = 0; i < 16; i++) begin
            case ($urandom_range(3))
               0: m[i] = $urandom();
               1: m[i] = $signed($urandom()) >>> 12;
               2: m[i] = $urandom_range(1) ? 32'h1_0000 : 32'hFFFF_0000;
               default: m[i] = 0;
            endcase
         end
         if (phase == 2) m[15] = 0;   // no translation term in w
         load_matrix(m);
         stall_on = (phase != 4);
         for (int i = 0; i < n / 8; i++)
            send_vertex(rand_vertex($urandom_range(3) == 0 ? 0 : $urandom_range(20)));
         drain();
      end
      stall_on = 1'b1;
   endtask

   // response sink
   always @(posedge clock) begin
      projected_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96],
                   rsp_tuser, rsp_tlast};
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected beat %h", $realtime, got);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch exp x=%h y=%h z=%h w=%h sat=%b last=%b",
                           $realtime, want.ox, want.oy, want.oz, want.ow, want.sat, want.last);
                  $display("%0t:          got x=%h y=%h z=%h w=%h sat=%b last=%b",
                           $realtime, got.ox, got.oy, got.oz, got.ow, got.sat, got.last);
                  errors++;
               end
            end
         end
         rsp_tready <= !idle_now();
      end
   end

   initial begin
      matrix_regs = '{64'h1_0000, 0, 64'h1_0000 << 32, 0, 0, 64'h1_0000, 0, 64'h1_0000 << 32};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_identity_edges();
      test_w_cases();
      test_random(1840);
      if (errors == 0) $display("tb_top: done, clean");
      else $display("tb_top: done, errors");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
